// ===== hw/rtl/slxfr_pkg.sv =====
// shared constants and types of the sync length xor frame receiver
package slxfr_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int PTR_W       = $clog2(MAX_PAYLOAD);
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 7;
    localparam int POS_W       = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int OUT_TDATA_W = 16;

    localparam logic [BYTE_W-1:0] SYNC_RESET   = 8'hAA;
    localparam logic [BYTE_W-1:0] TYPE_RESET   = 8'h01;
    localparam logic [LEN_W-1:0]  LENGTH_RESET = 7'd32;
    localparam logic [LEN_W-1:0]  LENGTH_LIMIT = LEN_W'(MAX_PAYLOAD);

    localparam logic [CFG_IDX_W-1:0] REG_SYNC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd2;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_CSUM    = 1'b1;

    localparam logic [2:0] ST_HUNT    = 3'd0;
    localparam logic [2:0] ST_TYPE    = 3'd1;
    localparam logic [2:0] ST_LEN_LO  = 3'd2;
    localparam logic [2:0] ST_LEN_HI  = 3'd3;
    localparam logic [2:0] ST_PAYLOAD = 3'd4;
    localparam logic [2:0] ST_CHECK   = 3'd5;
    localparam logic [2:0] ST_EMIT_RD = 3'd6;
    localparam logic [2:0] ST_EMIT_WR = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_value;
        logic [BYTE_W-1:0] accepted_type;
        logic [LEN_W-1:0]  expected_length;
    } cfg_t;

endpackage

// ===== hw/rtl/sync_length_xor_frame_receiver_unit.sv =====
// top level of the sync length xor frame receiver
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata rx_byte
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata data, position; tuser kind; tlast last
// cfg       in   cfg_valid/cfg_ready            cfg_index, cfg_data
//
// header and payload beats are taken whenever they are offered; the checksum beat is taken
// once the output register is free
// a good frame then plays out of the payload ram, each byte by a ram read
// and then an output register load; no input beat is taken meanwhile
// reset clears control state only; the payload ram needs no clearing
// a stall on m_axis holds the output register and, in playout, the ram read
module sync_length_xor_frame_receiver_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [slxfr_pkg::BYTE_W-1:0]        s_axis_tdata,   // [7:0] rx_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [slxfr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [7:0] data, [13:8] position, [15:14] zero
    output logic                                m_axis_tuser,   // [0] kind
    output logic                                m_axis_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [slxfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [slxfr_pkg::BYTE_W-1:0]        cfg_data
);

    import slxfr_pkg::*;

    cfg_t              cfg_reg;
    logic [2:0]        state_reg, state_next;
    logic [BYTE_W-1:0] length_low_reg, length_low_next;
    logic [CNT_W-1:0]  byte_count_reg, byte_count_next;
    logic [LEN_W-1:0]  frame_length_reg, frame_length_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic [PTR_W-1:0]  emit_idx_reg, emit_idx_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg, out_kind_next;
    logic [BYTE_W-1:0] out_data_reg, out_data_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;
    logic              out_last_reg, out_last_next;

    logic              in_beat;
    logic              out_free;
    logic              len_ok;
    logic              emit_last;
    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [BYTE_W-1:0] ram_rd_data;
    logic [CNT_W-1:0]  count_inc;

    slxfr_ram #(
        .DATA_W (BYTE_W),
        .DEPTH  (MAX_PAYLOAD)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (byte_count_reg[PTR_W-1:0]),
        .wr_data (s_axis_tdata),
        .rd_en   (ram_rd_en),
        .rd_addr (emit_idx_reg),
        .rd_data (ram_rd_data)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_value      <= SYNC_RESET;
            cfg_reg.accepted_type   <= TYPE_RESET;
            cfg_reg.expected_length <= LENGTH_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SYNC:   cfg_reg.sync_value      <= cfg_data;
                REG_TYPE:   cfg_reg.accepted_type   <= cfg_data;
                REG_LENGTH: cfg_reg.expected_length <= cfg_data[LEN_W-1:0];
                default:    ;
            endcase
        end
    end

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign count_inc = byte_count_reg + CNT_W'(1);
    assign emit_last = (CNT_W'(emit_idx_reg) + CNT_W'(1)) == CNT_W'(frame_length_reg);
    assign len_ok    = (s_axis_tdata == '0)
                    && (cfg_reg.expected_length != '0)
                    && (cfg_reg.expected_length <= LENGTH_LIMIT)
                    && (length_low_reg == BYTE_W'(cfg_reg.expected_length));

    always_comb
    begin
        if (state_reg inside {ST_HUNT, ST_TYPE, ST_LEN_LO, ST_LEN_HI, ST_PAYLOAD})
        begin
            s_axis_tready = 1'b1;
        end
        else if (state_reg == ST_CHECK)
        begin
            s_axis_tready = out_free;
        end
        else
        begin
            s_axis_tready = 1'b0;
        end
    end

    assign in_beat = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next        = state_reg;
        length_low_next   = length_low_reg;
        byte_count_next   = byte_count_reg;
        frame_length_next = frame_length_reg;
        xor_next          = xor_reg;
        emit_idx_next     = emit_idx_reg;
        out_valid_next    = out_valid_reg && !m_axis_tready;
        out_kind_next     = out_kind_reg;
        out_data_next     = out_data_reg;
        out_pos_next      = out_pos_reg;
        out_last_next     = out_last_reg;
        ram_wr_en         = 1'b0;
        ram_rd_en         = 1'b0;

        case (state_reg)
            ST_HUNT:
            begin
                if (in_beat && s_axis_tdata == cfg_reg.sync_value)
                begin
                    state_next = ST_TYPE;
                end
            end
            ST_TYPE:
            begin
                if (in_beat)
                begin
                    if (s_axis_tdata == cfg_reg.accepted_type)
                    begin
                        state_next = ST_LEN_LO;
                    end
                    else
                    begin
                        state_next      = ST_HUNT;
                        byte_count_next = '0;
                        xor_next        = '0;
                    end
                end
            end
            ST_LEN_LO:
            begin
                if (in_beat)
                begin
                    length_low_next = s_axis_tdata;
                    state_next      = ST_LEN_HI;
                end
            end
            ST_LEN_HI:
            begin
                if (in_beat)
                begin
                    byte_count_next = '0;
                    xor_next        = '0;
                    if (len_ok)
                    begin
                        frame_length_next = cfg_reg.expected_length;
                        state_next        = ST_PAYLOAD;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_PAYLOAD:
            begin
                if (in_beat)
                begin
                    ram_wr_en       = 1'b1;
                    xor_next        = xor_reg ^ s_axis_tdata;
                    byte_count_next = count_inc;
                    if (count_inc >= CNT_W'(frame_length_reg))
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (in_beat)
                begin
                    byte_count_next = '0;
                    xor_next        = '0;
                    if (s_axis_tdata == xor_reg)
                    begin
                        emit_idx_next = '0;
                        state_next    = ST_EMIT_RD;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_CSUM;
                        out_data_next  = '0;
                        out_pos_next   = '0;
                        out_last_next  = 1'b1;
                        state_next     = ST_HUNT;
                    end
                end
            end
            ST_EMIT_RD:
            begin
                ram_rd_en  = 1'b1;
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_PAYLOAD;
                    out_data_next  = ram_rd_data;
                    out_pos_next   = POS_W'(emit_idx_reg);
                    out_last_next  = emit_last;
                    if (emit_last)
                    begin
                        state_next = ST_HUNT;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + PTR_W'(1);
                        state_next    = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next      = ST_HUNT;
                byte_count_next = '0;
                xor_next        = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_HUNT;
            length_low_reg   <= '0;
            byte_count_reg   <= '0;
            frame_length_reg <= '0;
            xor_reg          <= '0;
            emit_idx_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            length_low_reg   <= length_low_next;
            byte_count_reg   <= byte_count_next;
            frame_length_reg <= frame_length_next;
            xor_reg          <= xor_next;
            emit_idx_reg     <= emit_idx_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - BYTE_W - POS_W){1'b0}}, out_pos_reg, out_data_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    // no input beat during playout
    a_no_input_in_playout: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_RD || state_reg == ST_EMIT_WR) |-> !s_axis_tready)
        else $error("input taken during playout");

    // payload count never runs past the latched length
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAYLOAD) |-> (byte_count_reg < CNT_W'(frame_length_reg)))
        else $error("payload count past frame length");

    // playout index stays inside the frame
    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_WR) |-> (CNT_W'(emit_idx_reg) < CNT_W'(frame_length_reg)))
        else $error("playout index past frame length");

    // a bad checksum gives one error beat marked last
    a_csum_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && state_reg == ST_CHECK && s_axis_tdata != xor_reg)
        |=> (out_valid_reg && out_kind_reg == KIND_CSUM && out_last_reg))
        else $error("checksum error beat missing");

endmodule

// ===== hw/rtl/slxfr_ram.sv =====
// single port write, single port read payload ram with registered read data
module slxfr_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
